// ----- design/rge_pkg.sv -----
// shared types, constants and helpers for the rectangular geofence block
// no dependencies
package rge_pkg;

  localparam int ZONE_REGS          = 3;
  localparam int NUM_ZONES_DEFAULT  = 3;
  localparam int BOUND_W            = 64;
  localparam int CFG_INDEX_W        = 3;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  localparam logic [BOUND_W-1:0] BOUNDS_RESET [2*ZONE_REGS] = '{
    64'd2491510524694632704, 64'd2405611178754632704,
    64'd2492369518154032704, 64'd2406470172214032704,
    64'd2493228511613432704, 64'd2407329165673432704
  };

  typedef struct packed {
    logic [ZONE_REGS-1:0] ev_mask;
    logic [ZONE_REGS-1:0] cur_mask;
    logic [31:0]          ts;
    logic signed [30:0]   lat;
    logic signed [31:0]   lon;
    logic [15:0]          speed;
    logic                 known;
    logic [ZONE_REGS-1:0] zone_bits;
    logic [31:0]          revision;
  } rge_job_t;

  function automatic logic in_box(input logic [BOUND_W-1:0] b, input logic signed [31:0] v);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = $signed(b[31:0]);
    hi = $signed(b[63:32]);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ----- design/rge_queue.sv -----
// short job queue between the classifier and the result sequencer
// depends on rge_pkg
module rge_queue
  import rge_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rge_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output rge_job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rge_job_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- design/rge_front.sv -----
// front end: zone bounds, item classification and geofence state update
// depends on rge_pkg
module rge_front
  import rge_pkg::*;
#(
  parameter int NUM_ZONES = NUM_ZONES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            tick_time_ms,
  input  logic signed [30:0]     latitude,
  input  logic signed [31:0]     longitude,
  input  logic [15:0]            ground_speed,
  input  logic                   fix_good,
  input  logic [31:0]            fix_revision,
  input  logic                   enabled,
  input  logic                   queue_full,
  output logic                   push,
  output rge_job_t               push_job
);

  localparam int ACTIVE     = (NUM_ZONES < ZONE_REGS) ? NUM_ZONES : ZONE_REGS;
  localparam int BOUND_REGS = 2 * ACTIVE;
  localparam int IDX_W      = $clog2(BOUND_REGS);

  logic [BOUND_W-1:0]   bounds [BOUND_REGS];
  logic [ZONE_REGS-1:0] inside_bits, inside_bits_next;
  logic                 position_flag, position_flag_next;
  logic [31:0]          change_count, change_count_next;
  logic [31:0]          seen_fix_revision, seen_fix_revision_next;
  logic                 fix_seen_flag, fix_seen_flag_next;
  logic                 baseline_flag, baseline_flag_next;
  logic                 enable_seen_flag;
  logic                 enable_last;

  logic signed [31:0]   lat_ext;
  logic [ZONE_REGS-1:0] cur;
  logic [ZONE_REGS-1:0] ev_mask;
  logic                 en_changed;
  logic                 repeat_fix;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign lat_ext  = {latitude[30], latitude};

  for (genvar z = 0; z < ZONE_REGS; z++) begin : g_zone
    if (z < ACTIVE) begin : g_on
      assign cur[z] = in_box(bounds[2*z], lat_ext) && in_box(bounds[2*z+1], longitude);
    end else begin : g_off
      assign cur[z] = 1'b0;
    end
  end

  always_comb begin
    inside_bits_next       = inside_bits;
    position_flag_next     = position_flag;
    change_count_next      = change_count;
    seen_fix_revision_next = seen_fix_revision;
    fix_seen_flag_next     = fix_seen_flag;
    baseline_flag_next     = baseline_flag;
    ev_mask                = '0;
    en_changed = !enable_seen_flag || (enabled != enable_last);
    repeat_fix = !en_changed && fix_seen_flag && (fix_revision == seen_fix_revision);
    if (!enabled) begin
      baseline_flag_next = 1'b0;
      if (position_flag) begin
        position_flag_next = 1'b0;
        change_count_next  = change_count + 1'b1;
      end
    end else if (!repeat_fix) begin
      fix_seen_flag_next     = 1'b1;
      seen_fix_revision_next = fix_revision;
      if (!fix_good) begin
        baseline_flag_next = 1'b0;
        if (position_flag) begin
          position_flag_next = 1'b0;
          change_count_next  = change_count + 1'b1;
        end
      end else begin
        if (baseline_flag) begin
          ev_mask = inside_bits ^ cur;
        end
        baseline_flag_next = 1'b1;
        position_flag_next = 1'b1;
        inside_bits_next   = cur;
        if (!position_flag || (inside_bits != cur)) begin
          change_count_next = change_count + 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_job.ev_mask   = ev_mask;
    push_job.cur_mask  = cur;
    push_job.ts        = tick_time_ms;
    push_job.lat       = latitude;
    push_job.lon       = longitude;
    push_job.speed     = ground_speed;
    push_job.known     = position_flag_next;
    push_job.zone_bits = inside_bits_next;
    push_job.revision  = change_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BOUND_REGS; i++) begin
        bounds[i] <= BOUNDS_RESET[i];
      end
    end else if (cfg_write && (cfg_index < CFG_INDEX_W'(BOUND_REGS))) begin
      bounds[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_bits       <= '0;
      position_flag     <= 1'b0;
      change_count      <= '0;
      seen_fix_revision <= '0;
      fix_seen_flag     <= 1'b0;
      baseline_flag     <= 1'b0;
      enable_seen_flag  <= 1'b0;
      enable_last       <= 1'b0;
    end else if (push) begin
      inside_bits       <= inside_bits_next;
      position_flag     <= position_flag_next;
      change_count      <= change_count_next;
      seen_fix_revision <= seen_fix_revision_next;
      fix_seen_flag     <= fix_seen_flag_next;
      baseline_flag     <= baseline_flag_next;
      enable_seen_flag  <= 1'b1;
      enable_last       <= enabled;
    end
  end

endmodule

// ----- design/rge_back.sv -----
// back end: walks one job's zone events in order, then its status item
// depends on rge_pkg
module rge_back
  import rge_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  rge_job_t           q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_event,
  output logic               event_kind,
  output logic [1:0]         zone_number,
  output logic [31:0]        event_time_ms,
  output logic signed [30:0] event_latitude,
  output logic signed [31:0] event_longitude,
  output logic [15:0]        event_speed,
  output logic               position_known,
  output logic [2:0]         inside_zones,
  output logic [31:0]        status_revision,
  output logic               last
);

  rge_job_t             job;
  logic                 busy;
  logic [ZONE_REGS-1:0] rem, rem_next;
  logic                 out_load;
  logic                 emit_status;
  logic [1:0]           zone_sel;

  assign out_load    = !out_valid || out_ready;
  assign emit_status = busy && out_load && (rem == '0);
  assign pop         = q_not_empty && (!busy || emit_status);

  always_comb begin
    zone_sel = '0;
    rem_next = rem;
    for (int z = ZONE_REGS - 1; z >= 0; z--) begin
      if (rem[z]) begin
        zone_sel = 2'(z);
      end
    end
    rem_next[zone_sel] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit_status) begin
        busy <= 1'b0;
      end
      if (out_load) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
      rem <= q_head.ev_mask;
    end else if (busy && out_load && (rem != '0)) begin
      rem <= rem_next;
    end
    if (busy && out_load) begin
      if (rem != '0) begin
        is_event        <= 1'b1;
        event_kind      <= job.cur_mask[zone_sel] ? KIND_ENTER : KIND_EXIT;
        zone_number     <= zone_sel + 2'd1;
        event_time_ms   <= job.ts;
        event_latitude  <= job.lat;
        event_longitude <= job.lon;
        event_speed     <= job.speed;
        position_known  <= 1'b0;
        inside_zones    <= '0;
        status_revision <= '0;
        last            <= 1'b0;
      end else begin
        is_event        <= 1'b0;
        event_kind      <= KIND_ENTER;
        zone_number     <= '0;
        event_time_ms   <= '0;
        event_latitude  <= '0;
        event_longitude <= '0;
        event_speed     <= '0;
        position_known  <= job.known;
        inside_zones    <= 3'(job.zone_bits);
        status_revision <= job.revision;
        last            <= 1'b1;
      end
    end
  end

endmodule

// ----- design/rectangular_geofence_events.sv -----
// rectangular geofence enter/exit detector, top level
// each item yields one result per zone event, then one status result
// throughput: one result per cycle while out_ready does not stall the output
// an item is accepted every cycle while the two-entry job queue has room
// reset: synchronous, clears all geofence state and loads the default zone bounds
// depends on rge_pkg, rge_front, rge_queue, rge_back
module rectangular_geofence_events
  import rge_pkg::*;
#(
  parameter int NUM_ZONES = NUM_ZONES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            tick_time_ms,
  input  logic signed [30:0]     latitude,
  input  logic signed [31:0]     longitude,
  input  logic [15:0]            ground_speed,
  input  logic                   fix_good,
  input  logic [31:0]            fix_revision,
  input  logic                   enabled,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_event,
  output logic                   event_kind,
  output logic [1:0]             zone_number,
  output logic [31:0]            event_time_ms,
  output logic signed [30:0]     event_latitude,
  output logic signed [31:0]     event_longitude,
  output logic [15:0]            event_speed,
  output logic                   position_known,
  output logic [2:0]             inside_zones,
  output logic [31:0]            status_revision,
  output logic                   last
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;
  rge_job_t push_job;
  rge_job_t q_head;

  rge_front #(
    .NUM_ZONES(NUM_ZONES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tick_time_ms(tick_time_ms),
    .latitude    (latitude),
    .longitude   (longitude),
    .ground_speed(ground_speed),
    .fix_good    (fix_good),
    .fix_revision(fix_revision),
    .enabled     (enabled),
    .queue_full  (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  rge_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  rge_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_event       (is_event),
    .event_kind     (event_kind),
    .zone_number    (zone_number),
    .event_time_ms  (event_time_ms),
    .event_latitude (event_latitude),
    .event_longitude(event_longitude),
    .event_speed    (event_speed),
    .position_known (position_known),
    .inside_zones   (inside_zones),
    .status_revision(status_revision),
    .last           (last)
  );

endmodule

// ----- tb/rectangular_geofence_events_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for rectangular_geofence_events: directed and random position fixes,
// zone bounds reprogrammed between phases, results checked against an in-file predictor
// depends on rge_pkg and the rectangular_geofence_events top level
module rectangular_geofence_events_tb
  import rge_pkg::*;
();

  localparam int ACTIVE_ZONES = 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_Z1_LAT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Z1_LON  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_LAT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_LON  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Z3_LAT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_Z3_LON  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  typedef logic [BOUND_W-1:0] zone_set_t [2*ZONE_REGS];

  typedef struct packed {
    logic [31:0]        ts;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [15:0]        speed;
    logic               valid;
    logic [31:0]        rev;
    logic               en;
  } gps_fix_t;

  typedef struct packed {
    logic               is_event;
    logic               kind;
    logic [1:0]         zone;
    logic [31:0]        time_ms;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [15:0]        speed;
    logic               known;
    logic [2:0]         zones;
    logic [31:0]        revision;
    logic               last;
  } fence_result_t;

  function automatic logic signed [31:0] lo_of(input logic [BOUND_W-1:0] b);
    return b[31:0];
  endfunction

  function automatic logic signed [31:0] hi_of(input logic [BOUND_W-1:0] b);
    return b[63:32];
  endfunction

  class fence_scoreboard;
    logic [BOUND_W-1:0] bounds [2*ZONE_REGS];
    logic [2:0]         inside_bits;
    bit                 known;
    logic [31:0]        change_count;
    logic [31:0]        seen_rev;
    bit                 rev_seen;
    bit                 has_baseline;
    bit                 en_seen;
    bit                 en_prev;
    fence_result_t      pending_results [$];
    int                 errors;

    function new();
      for (int i = 0; i < 2*ZONE_REGS; i++) bounds[i] = BOUNDS_RESET[i];
      inside_bits  = '0;
      known        = 0;
      change_count = '0;
      seen_rev     = '0;
      rev_seen     = 0;
      has_baseline = 0;
      en_seen      = 0;
      en_prev      = 0;
      errors       = 0;
    endfunction

    function void write_bound(input int idx, input logic [BOUND_W-1:0] v);
      if (idx < 2*ZONE_REGS) bounds[idx] = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic [2:0] zone_mask(input logic signed [30:0] lat, input logic signed [31:0] lon);
      logic signed [31:0] lat32;
      logic [2:0]         m;
      lat32 = lat;
      m = '0;
      for (int i = 0; i < ACTIVE_ZONES; i++) begin
        if (lat32 >= lo_of(bounds[2*i]) && lat32 <= hi_of(bounds[2*i]) &&
            lon >= lo_of(bounds[2*i+1]) && lon <= hi_of(bounds[2*i+1]))
          m[i] = 1'b1;
      end
      return m;
    endfunction

    function void lose_position();
      has_baseline = 0;
      if (known) begin
        known = 0;
        change_count = change_count + 1;
      end
    endfunction

    function void note_fix(input gps_fix_t f);
      bit            en_changed;
      bit            changed;
      logic [2:0]    cur;
      logic [2:0]    prev;
      fence_result_t r;
      en_changed = !en_seen || (f.en != en_prev);
      en_seen = 1;
      en_prev = f.en;
      if (!f.en) begin
        lose_position();
      end else if (!(!en_changed && rev_seen && f.rev == seen_rev)) begin
        rev_seen = 1;
        seen_rev = f.rev;
        if (!f.valid) begin
          lose_position();
        end else begin
          cur  = zone_mask(f.lat, f.lon);
          prev = inside_bits;
          if (has_baseline) begin
            for (int i = 0; i < ACTIVE_ZONES; i++) begin
              if (prev[i] != cur[i]) begin
                r = '0;
                r.is_event = 1'b1;
                r.kind     = cur[i] ? KIND_ENTER : KIND_EXIT;
                r.zone     = 2'(i + 1);
                r.time_ms  = f.ts;
                r.lat      = f.lat;
                r.lon      = f.lon;
                r.speed    = f.speed;
                pending_results.push_back(r);
              end
            end
          end
          has_baseline = 1;
          changed = !known || prev != cur;
          known = 1;
          inside_bits = cur;
          if (changed) change_count = change_count + 1;
        end
      end
      r = '0;
      r.known    = known;
      r.zones    = inside_bits;
      r.revision = change_count;
      r.last     = 1'b1;
      pending_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input fence_result_t got);
      fence_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("is_event", want.is_event, got.is_event);
      compare_field("event_kind", want.kind, got.kind);
      compare_field("zone_number", want.zone, got.zone);
      compare_field("event_time_ms", want.time_ms, got.time_ms);
      compare_field("event_latitude", want.lat, got.lat);
      compare_field("event_longitude", want.lon, got.lon);
      compare_field("event_speed", want.speed, got.speed);
      compare_field("position_known", want.known, got.known);
      compare_field("inside_zones", want.zones, got.zones);
      compare_field("status_revision", want.revision, got.revision);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BOUND_W-1:0]     cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            tick_time_ms = '0;
  logic signed [30:0]     latitude = '0;
  logic signed [31:0]     longitude = '0;
  logic [15:0]            ground_speed = '0;
  logic                   fix_good = 1'b0;
  logic [31:0]            fix_revision = '0;
  logic                   enabled = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   is_event;
  logic                   event_kind;
  logic [1:0]             zone_number;
  logic [31:0]            event_time_ms;
  logic signed [30:0]     event_latitude;
  logic signed [31:0]     event_longitude;
  logic [15:0]            event_speed;
  logic                   position_known;
  logic [2:0]             inside_zones;
  logic [31:0]            status_revision;
  logic                   last;

  fence_scoreboard sb = new();
  fence_result_t   seen_result;
  bit              idle_on = 1'b0;
  int              stall_left = 0;
  int              cycle_count = 0;
  logic [31:0]     last_rev = '0;

  rectangular_geofence_events uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tick_time_ms(tick_time_ms),
    .latitude(latitude),
    .longitude(longitude),
    .ground_speed(ground_speed),
    .fix_good(fix_good),
    .fix_revision(fix_revision),
    .enabled(enabled),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_event(is_event),
    .event_kind(event_kind),
    .zone_number(zone_number),
    .event_time_ms(event_time_ms),
    .event_latitude(event_latitude),
    .event_longitude(event_longitude),
    .event_speed(event_speed),
    .position_known(position_known),
    .inside_zones(inside_zones),
    .status_revision(status_revision),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result.is_event = is_event;
      seen_result.kind     = event_kind;
      seen_result.zone     = zone_number;
      seen_result.time_ms  = event_time_ms;
      seen_result.lat      = event_latitude;
      seen_result.lon      = event_longitude;
      seen_result.speed    = event_speed;
      seen_result.known    = position_known;
      seen_result.zones    = inside_zones;
      seen_result.revision = status_revision;
      seen_result.last     = last;
      sb.check_result(seen_result);
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic gps_fix_t fix_at(input logic [31:0] ts, input logic signed [31:0] lat,
                                      input logic signed [31:0] lon, input logic [15:0] speed,
                                      input bit valid, input logic [31:0] rev, input bit en);
    gps_fix_t f;
    f.ts    = ts;
    f.lat   = lat[30:0];
    f.lon   = lon;
    f.speed = speed;
    f.valid = valid;
    f.rev   = rev;
    f.en    = en;
    return f;
  endfunction

  function automatic logic signed [31:0] pick_coord(input logic [BOUND_W-1:0] b);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    lo = lo_of(b);
    hi = hi_of(b);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      4: return $urandom();
      default: begin
        if (hi < lo) return lo;
        span = longint'(hi) - longint'(lo) + 1;
        return 32'(longint'(lo) + longint'($urandom() % span));
      end
    endcase
  endfunction

  function automatic gps_fix_t make_fix();
    gps_fix_t           f;
    int                 zlat;
    int                 zlon;
    logic signed [31:0] lat32;
    f.ts    = $urandom();
    f.speed = 16'($urandom_range(0, 65535));
    f.en    = ($urandom_range(0, 11) != 0);
    f.valid = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 6))
      0: f.rev = last_rev;
      1: f.rev = $urandom();
      default: f.rev = last_rev + 1;
    endcase
    last_rev = f.rev;
    zlat = $urandom_range(0, ACTIVE_ZONES - 1);
    zlon = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ACTIVE_ZONES - 1) : zlat;
    lat32 = pick_coord(sb.bounds[2*zlat]);
    f.lat = lat32[30:0];
    f.lon = pick_coord(sb.bounds[2*zlon+1]);
    return f;
  endfunction

  function automatic zone_set_t random_zones();
    zone_set_t          zs;
    logic signed [31:0] mid [2];
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    mid[0] = $urandom_range(0, 1800000000) - 900000000;
    mid[1] = $urandom_range(0, 3600000000) - 1800000000;
    for (int i = 0; i < 2*ZONE_REGS; i++) begin
      lo = mid[i % 2] + $urandom_range(0, 100000);
      hi = ($urandom_range(0, 7) == 0) ? lo - 1 : lo + $urandom_range(0, 150000);
      zs[i] = {hi, lo};
    end
    return zs;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BOUND_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_bound(int'(idx), v);
    @(posedge clk);
  endtask

  task automatic program_zones(input zone_set_t zs);
    for (int i = 0; i < 2*ZONE_REGS; i++) write_reg(CFG_INDEX_W'(REG_Z1_LAT + i), zs[i]);
    cfg_write <= 1'b0;
  endtask

  task automatic push_fix(input gps_fix_t f);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    tick_time_ms <= f.ts;
    latitude     <= f.lat;
    longitude    <= f.lon;
    ground_speed <= f.speed;
    fix_good     <= f.valid;
    fix_revision <= f.rev;
    enabled      <= f.en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_fix(f);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) idle_on <= allow_idle && ($urandom_range(0, 3) != 0);
      if (allow_idle && $urandom_range(0, 59) == 0) drain();
      push_fix(make_fix());
    end
  endtask

  initial begin
    zone_set_t zs;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;

    // default zones after reset
    push_fix(fix_at(32'd1000, lo_of(BOUNDS_RESET[REG_Z1_LAT]) + 5,
                    lo_of(BOUNDS_RESET[REG_Z1_LON]) + 5, 16'd120, 1, 32'd1, 1));
    push_fix(fix_at(32'd1001, lo_of(BOUNDS_RESET[REG_Z2_LAT]),
                    hi_of(BOUNDS_RESET[REG_Z2_LON]), 16'd200, 1, 32'd2, 1));
    // repeated revision is skipped
    push_fix(fix_at(32'd1002, lo_of(BOUNDS_RESET[REG_Z3_LAT]),
                    lo_of(BOUNDS_RESET[REG_Z3_LON]), 16'd300, 1, 32'd2, 1));
    push_fix(fix_at(32'd1003, lo_of(BOUNDS_RESET[REG_Z1_LAT]),
                    lo_of(BOUNDS_RESET[REG_Z1_LON]), 16'd0, 1, 32'd3, 1));
    push_fix(fix_at(32'd1004, hi_of(BOUNDS_RESET[REG_Z1_LAT]),
                    hi_of(BOUNDS_RESET[REG_Z1_LON]), 16'd10, 1, 32'd4, 1));
    push_fix(fix_at(32'd1005, hi_of(BOUNDS_RESET[REG_Z1_LAT]) + 1,
                    hi_of(BOUNDS_RESET[REG_Z1_LON]), 16'd20, 1, 32'd5, 1));
    push_fix(fix_at(32'd1006, lo_of(BOUNDS_RESET[REG_Z2_LAT]) - 1,
                    lo_of(BOUNDS_RESET[REG_Z2_LON]), 16'd30, 1, 32'd6, 1));
    push_fix(fix_at(32'd1007, hi_of(BOUNDS_RESET[REG_Z3_LAT]),
                    hi_of(BOUNDS_RESET[REG_Z3_LON]), 16'd40, 1, 32'd7, 1));
    // invalid fix, then first valid fix without a baseline
    push_fix(fix_at(32'd1008, 0, 0, 16'd0, 0, 32'd8, 1));
    push_fix(fix_at(32'd1009, lo_of(BOUNDS_RESET[REG_Z3_LAT]) + 9,
                    lo_of(BOUNDS_RESET[REG_Z3_LON]) + 9, 16'd50, 1, 32'd9, 1));
    // disabled ticks, then re-enabled with an old revision
    push_fix(fix_at(32'd1010, 0, 0, 16'd0, 1, 32'd9, 0));
    push_fix(fix_at(32'd1011, 0, 0, 16'd0, 1, 32'd10, 0));
    push_fix(fix_at(32'd1012, lo_of(BOUNDS_RESET[REG_Z2_LAT]) + 7,
                    lo_of(BOUNDS_RESET[REG_Z2_LON]) + 7, 16'd60, 1, 32'd10, 1));
    push_fix(fix_at(32'd1013, lo_of(BOUNDS_RESET[REG_Z1_LAT]) + 7,
                    lo_of(BOUNDS_RESET[REG_Z1_LON]) + 7, 16'd70, 1, 32'd11, 1));
    push_fix(fix_at(32'd1014, 0, 0, 16'd0, 0, 32'd11, 1));
    push_fix(fix_at(32'd1015, 0, 0, 16'd0, 0, 32'd12, 1));
    push_fix(fix_at(32'd1016, 0, 0, 16'd0, 0, 32'd12, 1));
    // field extremes
    push_fix(fix_at(32'hFFFF_FFFF, 32'sh3FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1,
                    32'hFFFF_FFFF, 1));
    push_fix(fix_at(32'h0, 32'shC000_0000, 32'sh8000_0000, 16'h0, 1, 32'h0, 1));
    push_fix(fix_at(32'hA5A5_5A5A, lo_of(BOUNDS_RESET[REG_Z2_LAT]),
                    lo_of(BOUNDS_RESET[REG_Z2_LON]), 16'h5A5A, 1, 32'h1, 1));

    run_random(40, 1);
    drain();
    run_random(40, 1);
    drain();

    // whole plane, empty box, single point, plus writes to unused indexes
    zs[REG_Z1_LAT] = {32'h7FFF_FFFF, 32'h8000_0000};
    zs[REG_Z1_LON] = {32'h7FFF_FFFF, 32'h8000_0000};
    zs[REG_Z2_LAT] = {32'h8000_0000, 32'h7FFF_FFFF};
    zs[REG_Z2_LON] = {32'h7FFF_FFFF, 32'h8000_0000};
    zs[REG_Z3_LAT] = 64'hFFFF_FFFF_FFFF_FFFF;
    zs[REG_Z3_LON] = 64'h0;
    for (int i = 0; i < 2*ZONE_REGS; i++) write_reg(CFG_INDEX_W'(REG_Z1_LAT + i), zs[i]);
    write_reg(REG_SPARE_A, 64'h0);
    write_reg(REG_SPARE_B, 64'h0);
    cfg_write <= 1'b0;
    run_random(70, 1);
    drain();

    program_zones(random_zones());
    run_random(70, 1);
    drain();

    program_zones(random_zones());
    run_random(70, 1);
    drain();

    // defaults again, no idling to the end
    for (int i = 0; i < 2*ZONE_REGS; i++) zs[i] = BOUNDS_RESET[i];
    program_zones(zs);
    run_random(60, 0);
    drain();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rge_pkg.sv
design/rge_queue.sv
design/rge_front.sv
design/rge_back.sv
design/rectangular_geofence_events.sv
tb/rectangular_geofence_events_tb.sv
